/* sv/mtng_pkg.sv */
// Shared types, register indexes and sine table builder for the multi-tone NCO.
package mtng_pkg;

  typedef struct packed {
    logic       operation;
    logic [3:0] tone_select;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               limit_reached;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_PHASE,
    ST_LOOK,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } state_e;

  // configuration register indexes
  localparam logic CFG_BASE_STEP = 1'b0;
  localparam logic CFG_MAX_RUN   = 1'b1;

  localparam logic OP_TONE = 1'b0;
  localparam logic OP_TAP  = 1'b1;

  localparam logic [3:0] SEL_ALL = 4'd1;

  localparam logic [31:0] BASE_STEP_RST = 32'd8947849;
  localparam logic [23:0] MAX_RUN_RST   = 24'd14400000;
  localparam logic [23:0] COUNT_MAX     = 24'hFFFFFF;

  // rounding divisors: sum of all tones and a single tone
  localparam int unsigned DIV_W = 7;
  localparam logic [DIV_W-1:0] DIV_SUM = 7'd60;
  localparam logic [DIV_W-1:0] DIV_ONE = 7'd20;

  // reciprocals ceil(2^REC_SH / divisor), exact floor for numerators below 2^20
  localparam int unsigned REC_SH  = 26;
  localparam logic [21:0] REC_SUM = 22'd1118482;
  localparam logic [21:0] REC_ONE = 22'd3355444;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Quarter-wave entry: Taylor series of sin(pi/2 * a / 2^qbits), Q1.15.
  // Evaluated at elaboration only.
  function automatic logic [15:0] series_sine(input int unsigned a,
                                              input int unsigned qbits);
    longint unsigned x;
    longint unsigned term;
    longint unsigned t2;
    longint          sum;
    longint          r;
    x    = (64'(a) * HALF_PI_Q30) >> qbits;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      t2   = (term * x) >> 30;
      case (k)
        1:       term = t2 / 64'd6;
        2:       term = t2 / 64'd20;
        3:       term = t2 / 64'd42;
        4:       term = t2 / 64'd72;
        5:       term = t2 / 64'd110;
        6:       term = t2 / 64'd156;
        default: term = t2 / 64'd210;
      endcase
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + 64'sd16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return 16'(r);
  endfunction

endpackage

/* sv/multi_tone_nco_generator.sv */
// Multi-tone NCO: phase bank, shared phase adder, sine ROM and reciprocal rounding divider.
//
// Input channel (in_valid_i / in_ready_o, in_data_i): one beat per sample request.
//   operation = tap: step tone 0, output its sine unscaled.
//   operation = tone tick: tone_select 1 steps and sums every tone (sum / 60),
//   another select below NUM_TONES steps that tone only (value / 20), both rounded
//   half away from zero; a select at or above NUM_TONES returns 0, changes nothing.
// Output channel (out_valid_o / out_ready_i, out_data_o): one beat per input beat.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 = base phase step (also zeroes
//   every tone phase), index 1 = run limit. Always ready; write only while idle.
// Sequence from accept to output valid: each stepped tone passes ST_INC, ST_PHASE, ST_LOOK
//   and ST_ACC through the shared phase adder and sine ROM port, a scaled result then
//   passes ST_DIV for the reciprocal multiply, and ST_DONE loads the output register.
//   An invalid select goes straight to ST_DONE.
// One request is in flight at a time; in_ready_o is high only when the sequencer idles,
//   so the next beat can be taken in the cycle after the output register loads.
// The output register holds a finished beat while the receiver stalls; a new request
//   can be taken meanwhile and waits in its last step until the register frees.
// Reset zeroes all phases and the tick counter and loads default register values.
module multi_tone_nco_generator
  import mtng_pkg::*;
#(
  parameter int unsigned NUM_TONES      = 15,
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned TONE_W   = $clog2(NUM_TONES);
  localparam int unsigned QB       = SINE_ADDR_BITS - 2;
  localparam int unsigned QTR_SIZE = 1 << QB;
  localparam int unsigned ACC_W    = 16 + $clog2(NUM_TONES + 1);
  localparam int unsigned PROD_W   = REC_SH + ACC_W;

  // quarter-wave ROM, constant contents
  logic [15:0] qtab [QTR_SIZE+1];
  for (genvar g = 0; g <= QTR_SIZE; g++) begin : g_qtab
    assign qtab[g] = series_sine(g, QB);
  end

  state_e state_q, state_d;

  logic [31:0]       base_q;
  logic [23:0]       max_run_q;
  logic [23:0]       run_cnt_q;
  logic [31:0]       phase_q [NUM_TONES];
  logic [TONE_W-1:0] tone_q;
  logic              all_q;
  logic              scale_q;
  logic [31:0]       inc_q;
  logic [QB:0]       idx_q;
  logic              neg_q;
  logic signed [15:0]      sin_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]  num_q;
  logic              neg_res_q;
  logic              out_valid_q;
  out_beat_t         out_q;

  logic                    in_fire;
  logic                    cfg_fire;
  logic                    sel_ok;
  logic [TONE_W:0]         mul_k;
  logic [31:0]             ph_new;
  logic [SINE_ADDR_BITS-1:0] ph_addr;
  logic [QB-1:0]           ph_low;
  logic signed [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0]        acc_abs;
  logic [PROD_W-1:0]       quo_prod;
  logic [15:0]             quo16;
  logic                    out_free;
  logic                    last_tone;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign sel_ok      = {1'b0, in_data_i.tone_select} < 5'(NUM_TONES);
  assign out_free    = !out_valid_q || out_ready_i;
  assign last_tone   = !all_q || (tone_q == TONE_W'(NUM_TONES - 1));

  assign mul_k   = {tone_q, 1'b1};
  assign ph_new  = phase_q[tone_q] + inc_q;
  assign ph_addr = ph_new[31 -: SINE_ADDR_BITS];
  assign ph_low  = ph_addr[QB-1:0];

  assign acc_sum = acc_q + ACC_W'(sin_q);
  assign acc_abs = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);

  // floor(num / divisor) by reciprocal multiply
  assign quo_prod = PROD_W'(num_q) * PROD_W'(all_q ? REC_SUM : REC_ONE);
  assign quo16    = num_q[15:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.operation == OP_TAP || sel_ok) begin
            state_d = ST_INC;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_INC:   state_d = ST_PHASE;
      ST_PHASE: state_d = ST_LOOK;
      ST_LOOK:  state_d = ST_ACC;
      ST_ACC: begin
        if (!last_tone) begin
          state_d = ST_INC;
        end else if (scale_q) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV:   state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration, phase bank and tick counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= BASE_STEP_RST;
      max_run_q <= MAX_RUN_RST;
      run_cnt_q <= '0;
      for (int i = 0; i < NUM_TONES; i++) begin
        phase_q[i] <= '0;
      end
    end else begin
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_BASE_STEP: begin
            base_q <= cfg_data_i;
            for (int i = 0; i < NUM_TONES; i++) begin
              phase_q[i] <= '0;
            end
          end
          CFG_MAX_RUN: max_run_q <= cfg_data_i[23:0];
          default: ;
        endcase
      end else if (state_q == ST_PHASE) begin
        phase_q[tone_q] <= ph_new;
      end
      if (in_fire && in_data_i.operation == OP_TONE && sel_ok &&
          run_cnt_q != COUNT_MAX) begin
        run_cnt_q <= run_cnt_q + 24'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        acc_q     <= '0;
        num_q     <= '0;
        neg_res_q <= 1'b0;
        if (in_data_i.operation == OP_TAP) begin
          tone_q  <= '0;
          all_q   <= 1'b0;
          scale_q <= 1'b0;
        end else begin
          // summing starts from tone 0
          tone_q  <= (in_data_i.tone_select == SEL_ALL) ? '0
                                                        : TONE_W'(in_data_i.tone_select);
          all_q   <= (in_data_i.tone_select == SEL_ALL);
          scale_q <= 1'b1;
        end
      end
      ST_INC: inc_q <= 32'(base_q * mul_k);
      ST_PHASE: begin
        neg_q <= ph_addr[SINE_ADDR_BITS-1];
        idx_q <= ph_addr[SINE_ADDR_BITS-2] ? ((QB+1)'(QTR_SIZE) - {1'b0, ph_low})
                                           : {1'b0, ph_low};
      end
      ST_LOOK: sin_q <= neg_q ? -$signed(qtab[idx_q]) : $signed(qtab[idx_q]);
      ST_ACC: begin
        acc_q     <= acc_sum;
        neg_res_q <= acc_sum[ACC_W-1];
        num_q     <= acc_abs + ACC_W'(all_q ? (DIV_SUM >> 1) : (DIV_ONE >> 1));
        if (!last_tone) begin
          tone_q <= tone_q + TONE_W'(1);
        end
      end
      ST_DIV: num_q <= quo_prod[REC_SH +: ACC_W];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_q.limit_reached <= (run_cnt_q >= max_run_q);
      if (scale_q) begin
        out_q.sample <= neg_res_q ? $signed(16'(-quo16)) : $signed(quo16);
      end else begin
        out_q.sample <= acc_q[15:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
